### hdl/sha512_pkg.sv
// sha512 package: shared types, constants and round functions
// no dependencies
package sha512_pkg;

    localparam int WORD_W = 64;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

    localparam logic [63:0] H_INIT [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] PAD_WORD = 64'h8000000000000000;
    localparam logic [6:0]  LAST_ROUND = 7'd79;
    localparam logic [4:0]  LEN_SLOT = 5'd14;
    localparam logic [4:0]  BLOCK_WORDS = 5'd16;
    localparam logic [10:0] BLOCK_BITS = 11'd1024;

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        ror = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] sig0(input logic [63:0] x);
        sig0 = ror(x, 1) ^ ror(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] sig1(input logic [63:0] x);
        sig1 = ror(x, 19) ^ ror(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] bsig0(input logic [63:0] x);
        bsig0 = ror(x, 28) ^ ror(x, 34) ^ ror(x, 39);
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x);
        bsig1 = ror(x, 14) ^ ror(x, 18) ^ ror(x, 41);
    endfunction

endpackage

### hdl/sha512_if.sv
// valid/ready channel interfaces for the hash engine
// no dependencies
interface sha512_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last_word;
    modport source (output valid, message_word, byte_count, last_word, input ready);
    modport sink   (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface sha512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
    modport source (output valid, digest_word, word_index, digest_last, input ready);
    modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

### hdl/sha512_hash_engine.sv
// SHA-512 engine top: input queue feeding the compression core
// a message word is queued in the input queue; every 16th word starts 80 rounds and an add
// step in the core, which takes no word until it is done, so the queue fills while it is busy
// last word: take, then pad, 80 rounds and add per remaining block, one or two, then
// the eight digest words are sent out
// synchronous active-low reset restores the initial hash values and clears the length
module sha512_hash_engine
    import sha512_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sha512_in_if.sink    in,
    sha512_out_if.source out
);
    t_item q_in, q_out;
    logic  full, empty, pop;

    assign q_in = '{word: in.message_word, nbytes: in.byte_count, last: in.last_word};
    assign in.ready = !full;

    sha512_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(in.valid), .i_data(q_in), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(q_out)
    );

    sha512_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .i_item(q_out), .o_pop(pop), .out(out)
    );
endmodule

### hdl/sha512_fifo.sv
// short item queue between the front end and the compression core
// depends on sha512_pkg
module sha512_fifo
    import sha512_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);
    t_item      r_mem [4];
    logic [2:0] r_wp, r_rp;

    assign o_full  = (r_wp[1:0] == r_rp[1:0]) && (r_wp[2] != r_rp[2]);
    assign o_empty = (r_wp == r_rp);
    assign o_data  = r_mem[r_rp[1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 3'd1;
            if (i_pop && !o_empty) r_rp <= r_rp + 3'd1;
        end
        if (i_push && !o_full) r_mem[r_wp[1:0]] <= i_data;
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) <= 3'd4) else $error("fifo count out of range");
    a_nopush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |=> $stable(r_wp)) else $error("write into full fifo");
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |=> $stable(r_rp)) else $error("read from empty fifo");
`endif
endmodule

### hdl/sha512_core.sv
// back end: block buffer, padding, 80-round compression, digest output
// depends on sha512_pkg
module sha512_core
    import sha512_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_empty,
    input  t_item i_item,
    output logic  o_pop,
    sha512_out_if.source out
);
    t_state       r_state, n_state;
    logic [63:0]  r_h [8];
    logic [63:0]  r_v [8];
    logic [63:0]  r_w [16];
    logic [4:0]   r_fill;
    logic [127:0] r_len;
    logic [6:0]   r_rnd;
    logic         r_fin;     // current compression is the final one
    logic [2:0]   r_oidx;

    logic [3:0]   nb;
    logic [63:0]  keep, lastw, wt, wnew, t1, t2;
    logic [3:0]   t;
    logic         take;

    assign take  = (r_state == ST_IDLE) && !i_empty;
    assign o_pop = take;
    assign nb    = (i_item.nbytes > 4'd8) ? 4'd8 : i_item.nbytes;
    assign keep  = (nb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> (7'd8 * nb));
    assign lastw = (i_item.word & keep) | (PAD_WORD >> (7'd8 * nb));

    assign t    = r_rnd[3:0];
    assign wnew = r_w[t] + sig0(r_w[t + 4'd1]) + r_w[t + 4'd9] + sig1(r_w[t + 4'd14]);
    assign wt   = (r_rnd < 7'd16) ? r_w[t] : wnew;
    assign t1   = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + ROUND_K[r_rnd] + wt;
    assign t2   = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    if (!i_item.last) n_state = (r_fill == 5'd15) ? ST_ROUND : ST_IDLE;
                    else if (nb == 4'd8 && r_fill == 5'd15) n_state = ST_ROUND;
                    else n_state = ST_PAD;
                end
            end
            ST_ROUND: if (r_rnd == LAST_ROUND) n_state = ST_ADD;
            ST_ADD:   n_state = r_fin ? ST_OUT : (r_fill == 5'd0 ? ST_IDLE : ST_PAD);
            ST_PAD:   n_state = ST_ROUND;
            ST_OUT:   if (out.ready && r_oidx == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        out.valid       = (r_state == ST_OUT);
        out.digest_word = r_h[r_oidx];
        out.word_index  = r_oidx;
        out.digest_last = (r_oidx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: if (take) begin
                    r_fin <= 1'b0;
                    if (!i_item.last) begin
                        r_w[r_fill[3:0]] <= i_item.word;
                        r_fill <= (r_fill == 5'd15) ? 5'd0 : r_fill + 5'd1;
                        r_len  <= r_len + 128'd64;
                    end else begin
                        r_len <= r_len + {121'd0, nb, 3'd0};
                        if (nb == 4'd8) begin
                            r_w[r_fill[3:0]] <= i_item.word;
                            if (r_fill == 5'd15) begin
                                r_fill <= 5'd17; // pad word still owed to next block
                            end else begin
                                r_w[r_fill[3:0] + 4'd1] <= PAD_WORD;
                                r_fill <= r_fill + 5'd2;
                            end
                        end else begin
                            r_w[r_fill[3:0]] <= lastw;
                            r_fill <= r_fill + 5'd1;
                        end
                    end
                    if (n_state == ST_ROUND)
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
                ST_PAD: begin
                    // zero fill; length goes in if it fits, else another block follows
                    if (r_fill > LEN_SLOT && r_fill <= BLOCK_WORDS) begin
                        if (r_fill == 5'd15) r_w[15] <= '0;
                        r_fill <= 5'd18; // all-zero length block still owed
                    end else begin
                        if (r_fill == 5'd17) begin
                            r_w[0] <= PAD_WORD;
                            for (int i = 1; i < 14; i++) r_w[i] <= '0;
                        end else begin
                            for (int i = 0; i < 14; i++)
                                if (r_fill > BLOCK_WORDS || 5'(i) >= r_fill) r_w[i] <= '0;
                        end
                        r_w[14] <= r_len[127:64];
                        r_w[15] <= r_len[63:0];
                        r_fin   <= 1'b1;
                        r_fill  <= 5'd0;
                    end
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
                ST_ROUND: begin
                    if (r_rnd >= 7'd16) r_w[t] <= wnew;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= (r_rnd == LAST_ROUND) ? 7'd0 : r_rnd + 7'd1;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (r_fill == 5'd17) r_fill <= 5'd17;
                end
                ST_OUT: if (out.ready) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
                        r_len <= '0;
                        r_fin <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_ROUND |-> r_rnd == 7'd0) else $error("round count left over");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == ST_IDLE) else $error("item taken while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out.valid && !out.ready |=> $stable(r_oidx)) else $error("digest index moved");
`endif
endmodule
